// ===== rtl/mtb_pkg.sv =====
package mtb_pkg;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_SET_W  = 3'd1,
        OP_SET_T  = 3'd2,
        OP_BASE   = 3'd3,
        OP_OFFSET = 3'd4
    } op_t;

    localparam logic [0:0] CFG_SLEW   = 1'b0;
    localparam logic [0:0] CFG_THRESH = 1'b1;

    localparam logic [14:0] SLEW_RESET   = 15'd1911;
    localparam logic [14:0] THRESH_RESET = 15'd164;

    // Back-end command type.
    typedef enum logic [1:0] {
        CMD_BASE   = 2'd0,
        CMD_OFFSET = 2'd1,
        CMD_PASS   = 2'd2
    } cmd_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE, ST_READ, ST_MUL, ST_OUT
    } bst_t;

    // One classified vertex command that travels from front to back.
    typedef struct packed {
        cmd_t               cmd;
        logic [9:0]         vtx;
        logic signed [15:0] weight;
        logic [5:0][31:0]   comp;
    } vcmd_t;

    // Saturating blend: acc + floor((off*w + 2^13) / 2^14).
    function automatic logic [31:0] blend_sat(input logic [31:0] acc,
                                              input logic signed [47:0] prod);
        logic signed [48:0] r;
        logic signed [49:0] s;
        begin
            r = (49'(prod) + 49'sd8192) >>> 14;
            s = 50'($signed(acc)) + 50'(r);
            if (s > 50'sd2147483647)
                blend_sat = 32'h7fffffff;
            else if (s < -50'sd2147483648)
                blend_sat = 32'h80000000;
            else
                blend_sat = s[31:0];
        end
    endfunction

endpackage

// ===== rtl/mtb_front.sv =====
module mtb_front #(
    parameter int ACTIONS  = 16,
    parameter int VERTICES = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            in_op,
    input  logic [3:0]            in_action,
    input  logic [9:0]            in_vertex,
    input  logic                  in_auto,
    input  logic [15:0]           in_weight,
    input  logic [5:0][31:0]      in_comp,
    input  logic [14:0]           slew_step,
    input  logic [14:0]           threshold,
    output logic                  q_valid,
    input  logic                  q_ready,
    output mtb_pkg::vcmd_t        q_data
);
    import mtb_pkg::*;

    localparam int AW = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;

    logic signed [15:0] weight_reg [ACTIONS];
    logic signed [15:0] target_reg [ACTIONS];
    logic [ACTIONS-1:0] auto_reg;

    // Tick walker: one action per cycle.
    logic          tick_busy_reg;
    logic [AW-1:0] tick_idx_reg;

    logic          act_ok;
    logic [AW-1:0] aidx;
    logic signed [15:0] w_sel;
    logic [15:0]   w_mag;
    logic          vtx_ok;
    logic          take;
    logic          op_vert;

    assign act_ok = 32'(in_action) < ACTIONS;
    assign aidx   = AW'(in_action);
    assign vtx_ok = 32'(in_vertex) < VERTICES;
    assign w_sel  = act_ok ? weight_reg[aidx] : 16'sd0;
    assign w_mag  = w_sel[15] ? 16'(-w_sel) : w_sel;
    assign op_vert = (in_op == OP_BASE || in_op == OP_OFFSET) && vtx_ok;

    assign in_ready = !tick_busy_reg && (!op_vert || q_ready);
    assign take     = in_valid && in_ready;
    assign q_valid  = in_valid && !tick_busy_reg && op_vert;

    // Classified command into the queue.
    always_comb begin
        q_data.vtx    = in_vertex;
        q_data.comp   = in_comp;
        q_data.weight = w_sel;
        if (in_op == OP_BASE)
            q_data.cmd = CMD_BASE;
        else if (w_mag > {1'b0, threshold})
            q_data.cmd = CMD_OFFSET;
        else
            q_data.cmd = CMD_PASS;
    end

    // Slew step for the action under the walker.
    logic signed [16:0] diff;
    logic signed [16:0] st;
    logic signed [15:0] slewed;
    always_comb begin
        diff = 17'(target_reg[tick_idx_reg]) - 17'(weight_reg[tick_idx_reg]);
        st   = {2'b00, slew_step};
        if (diff > st)
            slewed = 16'(17'(weight_reg[tick_idx_reg]) + st);
        else if (diff < -st)
            slewed = 16'(17'(weight_reg[tick_idx_reg]) - st);
        else
            slewed = target_reg[tick_idx_reg];
    end

    // Control of the tick walker.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_busy_reg <= 1'b0;
            tick_idx_reg  <= '0;
        end else if (tick_busy_reg) begin
            if (32'(tick_idx_reg) == ACTIONS - 1) begin
                tick_busy_reg <= 1'b0;
                tick_idx_reg  <= '0;
            end else begin
                tick_idx_reg <= tick_idx_reg + 1'b1;
            end
        end else if (take && in_op == OP_TICK) begin
            tick_busy_reg <= 1'b1;
            tick_idx_reg  <= '0;
        end
    end

    // Action table.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ACTIONS; i++) begin
                weight_reg[i] <= '0;
                target_reg[i] <= '0;
            end
            auto_reg <= '0;
        end else if (tick_busy_reg) begin
            if (auto_reg[tick_idx_reg])
                weight_reg[tick_idx_reg] <= slewed;
        end else if (take && act_ok) begin
            if (in_op == OP_SET_W) begin
                weight_reg[aidx] <= in_weight;
            end else if (in_op == OP_SET_T) begin
                target_reg[aidx] <= in_weight;
                auto_reg[aidx]   <= in_auto;
            end
        end
    end
endmodule

// ===== rtl/mtb_queue.sv =====
module mtb_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  mtb_pkg::vcmd_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output mtb_pkg::vcmd_t out_data
);
    import mtb_pkg::*;

    // Two-entry queue.
    vcmd_t      mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    logic push, pop;
    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wp_reg] <= in_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/mtb_back.sv =====
module mtb_back #(
    parameter int VERTICES = 1024
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  mtb_pkg::vcmd_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [9:0]     out_vertex,
    output logic [5:0][31:0] out_comp
);
    import mtb_pkg::*;

    localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;

    bst_t state_reg, state_next;

    logic [191:0] acc_mem [VERTICES];
    logic [191:0] rd_reg;
    vcmd_t        cmd_reg;
    logic signed [5:0][47:0] prod_reg;
    logic [5:0][31:0] res_reg;
    logic [191:0] res_next_flat;
    logic [5:0][31:0] res_next;

    logic take;
    assign take = in_valid && in_ready;
    assign in_ready = state_reg == ST_IDLE;
    assign out_valid = state_reg == ST_OUT;
    assign out_vertex = cmd_reg.vtx;
    assign out_comp = res_reg;

    // Accumulator memory: base write on accept, blended write-back before output.
    always_ff @(posedge aclk) begin
        if (take && in_data.cmd == CMD_BASE)
            acc_mem[VW'(in_data.vtx)] <= in_data.comp;
        else if (state_reg == ST_MUL && cmd_reg.cmd == CMD_OFFSET)
            acc_mem[VW'(cmd_reg.vtx)] <= res_next_flat;
        if (take)
            rd_reg <= acc_mem[VW'(in_data.vtx)];
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            if (cmd_reg.cmd == CMD_OFFSET)
                res_next[i] = blend_sat(rd_reg[i*32 +: 32], prod_reg[i]);
            else
                res_next[i] = rd_reg[i*32 +: 32];
        end
        res_next_flat = res_next;
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (take)
            cmd_reg <= in_data;
        if (state_reg == ST_READ)
            for (int i = 0; i < 6; i++)
                prod_reg[i] <= 48'($signed(cmd_reg.comp[i])) * 48'($signed(cmd_reg.weight));
        if (state_reg == ST_MUL)
            res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Sequencer: read, multiply, blend and write back (offset commands only), then present.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take && in_data.cmd != CMD_BASE) state_next = ST_READ;
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/morph_target_blend_unit.sv =====
// Morph target blend unit. Items arrive on the s_ stream, with the operation in s_tuser,
// and blended vertices leave on the m_ stream; an offset item for an in-range vertex
// produces one result, every other item produces none. A tick walks the action table
// one action per cycle, and an offset vertex passes the back-end steps in order:
// accumulator read, multiply, blend and write back when its weight magnitude is above
// the threshold, output. A two-entry queue parts the front end, which owns the weight
// table, from the back end, which owns the accumulator memory. The accumulator needs
// no clearing after reset, but a vertex must get a base item before any offset.
module morph_target_blend_unit #(
    parameter int ACTIONS  = 16,
    parameter int VERTICES = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation.
    input  logic [2:0]   s_tuser,
    // action_index, vertex_index, slew enable, weight_value, pos_x, pos_y, pos_z,
    // norm_x, norm_y, norm_z; 1 zero bit on top.
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_vertex, out_x, out_y, out_z, out_nx, out_ny, out_nz; 6 zero bits on top.
    output logic [207:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [14:0]  cfg_data
);
    import mtb_pkg::*;

    logic [14:0] slew_reg, thresh_reg;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slew_reg   <= SLEW_RESET;
            thresh_reg <= THRESH_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_SLEW)
                slew_reg <= cfg_data;
            else
                thresh_reg <= cfg_data;
        end
    end

    logic   fq_valid, fq_ready, qb_valid, qb_ready;
    vcmd_t  fq_data, qb_data;
    logic [5:0][31:0] in_comp, out_comp;
    logic [9:0] out_vertex;

    always_comb begin
        for (int i = 0; i < 6; i++)
            in_comp[i] = s_tdata[31 + i*32 +: 32];
    end

    mtb_front #(.ACTIONS(ACTIONS), .VERTICES(VERTICES)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_op(s_tuser), .in_action(s_tdata[3:0]), .in_vertex(s_tdata[13:4]),
        .in_auto(s_tdata[14]), .in_weight(s_tdata[30:15]), .in_comp(in_comp),
        .slew_step(slew_reg), .threshold(thresh_reg),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    mtb_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
    );

    mtb_back #(.VERTICES(VERTICES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(qb_valid), .in_ready(qb_ready), .in_data(qb_data),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_vertex(out_vertex), .out_comp(out_comp)
    );

    assign m_tdata = {6'd0, out_comp[5], out_comp[4], out_comp[3], out_comp[2],
                      out_comp[1], out_comp[0], out_vertex};
endmodule
